// ----- rtl/mre_pkg.sv -----
// ----------------------------------------------------------------------------
// mre_pkg
// Types, codes and helper functions for the mouse report encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mre_pkg;

    localparam int FIELD_COORD_BITS = 12;
    localparam int DEC_BITS         = 13;
    localparam int FRAME_BYTES      = 16;
    localparam int FRAME_BITS       = FRAME_BYTES * 8;
    localparam int COUNT_BITS       = $clog2(FRAME_BYTES + 1);

    // event kinds
    localparam logic [2:0] KIND_PRESS       = 3'd0;
    localparam logic [2:0] KIND_RELEASE     = 3'd1;
    localparam logic [2:0] KIND_MOVE        = 3'd2;
    localparam logic [2:0] KIND_SCROLL_UP   = 3'd3;
    localparam logic [2:0] KIND_SCROLL_DOWN = 3'd4;

    localparam logic [2:0] BTN_NONE = 3'd3;

    // report modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_PRESS  = 2'd1;
    localparam logic [1:0] MODE_BUTTON = 2'd2;
    localparam logic [1:0] MODE_ANY    = 2'd3;

    localparam logic ENC_LEGACY = 1'b0;
    localparam logic ENC_SGR    = 1'b1;

    // configuration register indexes
    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_ENCODING = 1'b1;

    // button codes
    localparam logic [6:0] CODE_SCROLL_UP   = 7'd64;
    localparam logic [6:0] CODE_SCROLL_DOWN = 7'd65;
    localparam logic [6:0] CODE_RELEASE     = 7'd3;
    localparam logic [6:0] CODE_WHEEL_BASE  = 7'd64;
    localparam logic [6:0] CODE_MOTION      = 7'd32;
    localparam logic [6:0] CODE_NONE        = 7'd3;

    localparam logic [7:0] CODE_OFFSET  = 8'd32;
    localparam logic [7:0] COORD_OFFSET = 8'd33;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BRACK = 8'h5B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UPM   = 8'h4D;
    localparam logic [7:0] CH_LOWM  = 8'h6D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // reciprocals of powers of ten, scaled by 2**DEC_SHIFT and rounded up
    localparam int          DEC_SHIFT  = 24;
    localparam int          RECIP_BITS = 21;
    localparam int          PROD_BITS  = DEC_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_10   = RECIP_BITS'(1677722);
    localparam logic [RECIP_BITS-1:0] RECIP_100  = RECIP_BITS'(167773);
    localparam logic [RECIP_BITS-1:0] RECIP_1000 = RECIP_BITS'(16778);

    typedef struct packed {
        logic [31:0] chars;   // most significant digit in the lowest byte
        logic [2:0]  len;
    } dec_t;

    function automatic logic [DEC_BITS-1:0] scaled_quot(
        input logic [DEC_BITS-1:0]   v,
        input logic [RECIP_BITS-1:0] recip
    );
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(v) * PROD_BITS'(recip);
        return prod[DEC_SHIFT +: DEC_BITS];
    endfunction

    function automatic logic [7:0] digit_char(
        input logic [DEC_BITS-1:0] hi,
        input logic [DEC_BITS-1:0] lo_quot
    );
        logic [DEC_BITS-1:0] rem;
        rem = hi - DEC_BITS'(lo_quot * DEC_BITS'(10));
        return CH_ZERO | {4'b0000, rem[3:0]};
    endfunction

    // values up to 4096
    function automatic dec_t to_decimal(input logic [DEC_BITS-1:0] v);
        logic [DEC_BITS-1:0] q1;
        logic [DEC_BITS-1:0] q2;
        logic [DEC_BITS-1:0] q3;
        logic [7:0]          c0;
        logic [7:0]          c1;
        logic [7:0]          c2;
        logic [7:0]          c3;
        dec_t                d;
        q1 = scaled_quot(v, RECIP_10);
        q2 = scaled_quot(v, RECIP_100);
        q3 = scaled_quot(v, RECIP_1000);
        c0 = digit_char(v, q1);
        c1 = digit_char(q1, q2);
        c2 = digit_char(q2, q3);
        c3 = CH_ZERO | {4'b0000, q3[3:0]};
        if (v >= DEC_BITS'(1000)) begin
            d.chars = {c0, c1, c2, c3};
            d.len   = 3'd4;
        end else if (v >= DEC_BITS'(100)) begin
            d.chars = {8'h00, c0, c1, c2};
            d.len   = 3'd3;
        end else if (v >= DEC_BITS'(10)) begin
            d.chars = {16'h0000, c0, c1};
            d.len   = 3'd2;
        end else begin
            d.chars = {24'h000000, c0};
            d.len   = 3'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mouse_report_encoder.sv -----
// ----------------------------------------------------------------------------
// mouse_report_encoder
// Turns one pointer event into the byte stream of a terminal mouse report.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata event fields, s_tuser kind
//  m_       out        m_tvalid/m_tready  m_tdata report byte, m_tlast end
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  An item passes an input register, is built into a full report in one
//  pass and is then sent one byte a cycle while m_tready allows: 6 bytes
//  for a legacy report, 9 to 16 for an SGR report. The next item is
//  taken while the current report drains; unreported items leave the
//  input register without waiting; bytes go via frame and output regs.
//  aresetn is synchronous and active low; mode resets to none.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_report_encoder #(
    parameter int COORD_BITS = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // which_button[2:0], shift_held[3], alt_held[4], ctrl_held[5],
    // column[17:6], line[29:18], zero fill [31:30]
    input  wire logic [31:0] s_tdata,
    // event_kind[2:0]
    input  wire logic [2:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]       m_tdata,
    output logic             m_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [1:0]  cfg_data
);

    localparam int CB = mre_pkg::FIELD_COORD_BITS;
    localparam int USED_BITS = (COORD_BITS < CB) ? COORD_BITS : CB;
    localparam logic [CB-1:0] COORD_MASK = CB'((32'd1 << USED_BITS) - 32'd1);
    localparam int FB = mre_pkg::FRAME_BITS;
    localparam int NB = mre_pkg::COUNT_BITS;
    localparam int DB = mre_pkg::DEC_BITS;

    logic [1:0]    mode_reg;
    logic          enc_reg;

    logic          in_valid_reg;
    logic [2:0]    kind_reg;
    logic [2:0]    btn_reg;
    logic          shift_reg;
    logic          alt_reg;
    logic          ctrl_reg;
    logic [CB-1:0] col_reg;
    logic [CB-1:0] row_reg;

    logic          frame_valid_reg;
    logic [FB-1:0] frame_reg;
    logic [NB-1:0] rem_reg;

    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;
    logic          m_tlast_reg;

    logic          reported;
    logic [6:0]    mods;
    logic [6:0]    base_code;
    logic [6:0]    sgr_code;
    logic [CB-1:0] col_m;
    logic [CB-1:0] row_m;
    mre_pkg::dec_t code_dec;
    mre_pkg::dec_t col_dec;
    mre_pkg::dec_t row_dec;
    logic [FB-1:0] sgr_frame;
    logic [FB-1:0] new_frame;
    logic [NB-1:0] new_len;

    logic          out_free;
    logic          emit;
    logic          emit_last;
    logic          frame_free;
    logic          advance;
    logic          load;

    logic          in_valid_next;
    logic          frame_valid_next;
    logic [FB-1:0] frame_next;
    logic [NB-1:0] rem_next;
    logic          m_tvalid_next;
    logic [7:0]    m_tdata_next;
    logic          m_tlast_next;

    always_comb begin
        case (mode_reg)
            mre_pkg::MODE_PRESS: begin
                reported = (kind_reg == mre_pkg::KIND_PRESS)
                        || (kind_reg == mre_pkg::KIND_SCROLL_UP)
                        || (kind_reg == mre_pkg::KIND_SCROLL_DOWN);
            end
            mre_pkg::MODE_BUTTON: begin
                reported = (kind_reg <= mre_pkg::KIND_SCROLL_DOWN)
                        && !((kind_reg == mre_pkg::KIND_MOVE)
                             && (btn_reg == mre_pkg::BTN_NONE));
            end
            mre_pkg::MODE_ANY: begin
                reported = (kind_reg <= mre_pkg::KIND_SCROLL_DOWN);
            end
            default: begin
                reported = 1'b0;
            end
        endcase
    end

    always_comb begin
        mods = {2'b00, ctrl_reg, alt_reg, shift_reg, 2'b00};
        case (kind_reg)
            mre_pkg::KIND_SCROLL_UP:   base_code = mre_pkg::CODE_SCROLL_UP;
            mre_pkg::KIND_SCROLL_DOWN: base_code = mre_pkg::CODE_SCROLL_DOWN;
            mre_pkg::KIND_RELEASE:     base_code = mre_pkg::CODE_RELEASE;
            mre_pkg::KIND_MOVE: begin
                base_code = mre_pkg::CODE_MOTION
                          | ((btn_reg < mre_pkg::BTN_NONE) ? {4'b0000, btn_reg}
                                                           : mre_pkg::CODE_NONE);
            end
            default: begin
                base_code = btn_reg[2] ? (mre_pkg::CODE_WHEEL_BASE | {5'b00000, btn_reg[1:0]})
                                       : {4'b0000, btn_reg};
            end
        endcase
        if (kind_reg == mre_pkg::KIND_RELEASE) begin
            sgr_code = ((btn_reg < mre_pkg::BTN_NONE) ? {4'b0000, btn_reg} : 7'd0) | mods;
        end else begin
            sgr_code = base_code | mods;
        end
    end

    always_comb begin
        col_m    = col_reg & COORD_MASK;
        row_m    = row_reg & COORD_MASK;
        code_dec = mre_pkg::to_decimal(DB'(sgr_code));
        col_dec  = mre_pkg::to_decimal(DB'(col_m) + DB'(1));
        row_dec  = mre_pkg::to_decimal(DB'(row_m) + DB'(1));

        sgr_frame = FB'((kind_reg == mre_pkg::KIND_RELEASE) ? mre_pkg::CH_LOWM
                                                             : mre_pkg::CH_UPM);
        sgr_frame = (sgr_frame << {row_dec.len, 3'b000}) | FB'(row_dec.chars);
        sgr_frame = (sgr_frame << 8) | FB'(mre_pkg::CH_SEMI);
        sgr_frame = (sgr_frame << {col_dec.len, 3'b000}) | FB'(col_dec.chars);
        sgr_frame = (sgr_frame << 8) | FB'(mre_pkg::CH_SEMI);
        sgr_frame = (sgr_frame << {code_dec.len, 3'b000}) | FB'(code_dec.chars);
        sgr_frame = (sgr_frame << 24)
                  | FB'({mre_pkg::CH_LT, mre_pkg::CH_BRACK, mre_pkg::CH_ESC});

        if (enc_reg == mre_pkg::ENC_SGR) begin
            new_frame = sgr_frame;
            new_len   = NB'(6) + NB'(code_dec.len) + NB'(col_dec.len)
                      + NB'(row_dec.len);
        end else begin
            new_frame = FB'({row_m[7:0] + mre_pkg::COORD_OFFSET,
                             col_m[7:0] + mre_pkg::COORD_OFFSET,
                             {1'b0, base_code | mods} + mre_pkg::CODE_OFFSET,
                             mre_pkg::CH_UPM, mre_pkg::CH_BRACK, mre_pkg::CH_ESC});
            new_len   = NB'(6);
        end
    end

    always_comb begin
        out_free   = !m_tvalid_reg || m_tready;
        emit       = frame_valid_reg && out_free;
        emit_last  = emit && (rem_reg == NB'(1));
        frame_free = !frame_valid_reg || emit_last;
        advance    = in_valid_reg && (!reported || frame_free);
        load       = advance && reported;
        s_tready   = !in_valid_reg || advance;

        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        frame_valid_next = frame_valid_reg;
        frame_next       = frame_reg;
        rem_next         = rem_reg;
        if (load) begin
            frame_valid_next = 1'b1;
            frame_next       = new_frame;
            rem_next         = new_len;
        end else if (emit) begin
            frame_valid_next = !emit_last;
            frame_next       = frame_reg >> 8;
            rem_next         = rem_reg - NB'(1);
        end

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = frame_reg[7:0];
            m_tlast_next  = (rem_reg == NB'(1));
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= mre_pkg::MODE_NONE;
            enc_reg         <= mre_pkg::ENC_LEGACY;
            in_valid_reg    <= 1'b0;
            frame_valid_reg <= 1'b0;
            rem_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    mre_pkg::REG_MODE:     mode_reg <= cfg_data;
                    mre_pkg::REG_ENCODING: enc_reg  <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            in_valid_reg    <= in_valid_next;
            frame_valid_reg <= frame_valid_next;
            rem_reg         <= rem_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser;
            btn_reg   <= s_tdata[2:0];
            shift_reg <= s_tdata[3];
            alt_reg   <= s_tdata[4];
            ctrl_reg  <= s_tdata[5];
            col_reg   <= s_tdata[17:6];
            row_reg   <= s_tdata[29:18];
        end
        frame_reg   <= frame_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

endmodule

`default_nettype wire
